// ----- hw/rtl/ikr_pkg.sv -----
// Shared constants and types for the integer k-th root block.
package ikr_pkg;

    // Field widths fixed by the stream payloads
    localparam int FIELD_W     = 64;
    localparam int ORDER_W     = 7;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 64;

    // Default radicand width
    localparam int VALUE_W_DEF = 64;

    // Status from the sequencer to the stream wrapper
    typedef struct packed {
        logic idle;   // ready to take a new operand
        logic done;   // result valid this cycle, output slot free
    } ikr_status_t;

endpackage

// ----- hw/rtl/ikr_mul.sv -----
// Shared registered multiplier: one partial product per cycle.
module ikr_mul
    import ikr_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 33
) (
    input  logic            aclk,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic [AW+BW-1:0] p
);

    logic [AW+BW-1:0] p_reg;

    // Product registered before use
    always_ff @(posedge aclk) begin
        p_reg <= (AW+BW)'(a) * (AW+BW)'(b);
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/ikr_seq.sv -----
// Binary-search sequencer for the k-th root around the shared multiplier.
module ikr_seq
    import ikr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] x_in,
    input  logic [ORDER_W-1:0]     k_in,
    input  logic                   out_free,
    output ikr_status_t            status,
    output logic [FIELD_W-1:0]     root
);

    // Half width of the radicand; candidates stay at or below 2^HW
    localparam int W  = VALUE_WIDTH;
    localparam int HW = (W + 1) / 2;
    localparam int CW = HW + 1;
    localparam int PW = HW + CW;
    localparam int SW = PW + HW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [W-1:0]       x_reg, x_next;
    logic [ORDER_W-1:0] k_reg, k_next;
    logic [ORDER_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [W-1:0]       acc_reg, acc_next;
    logic [PW-1:0]      plo_reg, plo_next;
    logic [FIELD_W-1:0] root_reg, root_next;

    logic [HW-1:0]      mul_a;
    logic [PW-1:0]      mul_p;
    logic [SW-1:0]      full;
    logic               over;
    logic [CW-1:0]      span;
    logic [CW-1:0]      mid_calc;

    // Low half first, then high half of the running power
    assign mul_a = (state_reg == S_MUL_HI) ? HW'(acc_reg[W-1:HW]) : acc_reg[HW-1:0];

    ikr_mul #(
        .AW (HW),
        .BW (CW)
    ) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mid_reg),
        .p    (mul_p)
    );

    // Recombine partial products and compare against the radicand
    assign full = (SW'(mul_p) << HW) + SW'(plo_reg);
    assign over = full > SW'(x_reg);

    // Upper midpoint of [lo, hi]
    assign span     = hi_reg - lo_reg + CW'(1);
    assign mid_calc = lo_reg + (span >> 1);

    // Next-state and datapath
    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        acc_next   = acc_reg;
        plo_next   = plo_reg;
        root_next  = root_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    x_next = x_in;
                    k_next = k_in;
                    if (k_in < ORDER_W'(2) || x_in < W'(2)) begin
                        // identity cases: order 0/1 or radicand 0/1
                        root_next  = FIELD_W'(x_in);
                        state_next = S_DONE;
                    end else begin
                        lo_next    = CW'(1);
                        hi_next    = CW'(1) << HW;
                        state_next = S_MID;
                    end
                end
            end
            S_MID: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_calc;
                    acc_next   = W'(mid_calc);
                    cnt_next   = k_reg - ORDER_W'(1);
                    state_next = S_MUL_LO;
                end else begin
                    root_next  = FIELD_W'(lo_reg);
                    state_next = S_DONE;
                end
            end
            S_MUL_LO: begin
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                plo_next   = mul_p;
                state_next = S_SUM;
            end
            S_SUM: begin
                if (over) begin
                    // candidate too large: stop early
                    hi_next    = mid_reg - CW'(1);
                    state_next = S_MID;
                end else begin
                    acc_next = full[W-1:0];
                    if (cnt_reg == ORDER_W'(1)) begin
                        lo_next    = mid_reg;
                        state_next = S_MID;
                    end else begin
                        cnt_next   = cnt_reg - ORDER_W'(1);
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg    <= x_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        acc_reg  <= acc_next;
        plo_reg  <= plo_next;
        root_reg <= root_next;
    end

    assign status.idle = (state_reg == S_IDLE);
    assign status.done = (state_reg == S_DONE) && out_free;
    assign root        = root_reg;

endmodule

// ----- hw/rtl/integer_kth_root_top.sv -----
// Integer k-th root: stream wrapper around the search sequencer.
//
//  channel | dir | fields (low bit first)              | transfer when
//  s_axis  | in  | value[63:0], order[70:64], pad      | s_axis_tvalid & s_axis_tready
//  m_axis  | out | root[63:0]                          | m_axis_tvalid & m_axis_tready
//
// One operand at a time. Order 0/1 or a radicand below 2: the sequencer goes straight
// to its done state. Otherwise ceil(W/2) search steps over [1, 2^ceil(W/2)] on the
// single shared ceil(W/2) x (ceil(W/2)+1) multiplier; each step is a midpoint state,
// then per multiply a low-half, a high-half and a sum state; a step needs 1 to order-1
// multiplies. The result then passes through the done state into the output register.
// Reset (aresetn low, synchronous) empties the output register and idles.
// A stalled result holds in the output register while the next operand is taken.
module integer_kth_root_top
    import ikr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // value[63:0], order[70:64], zero[71]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // root[63:0]
);

    ikr_status_t        status;
    logic [FIELD_W-1:0] root;
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic               out_free;
    logic               start;

    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = status.idle;
    assign start         = s_axis_tvalid && status.idle;

    ikr_seq #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .x_in     (s_axis_tdata[VALUE_WIDTH-1:0]),
        .k_in     (s_axis_tdata[FIELD_W +: ORDER_W]),
        .out_free (out_free),
        .status   (status),
        .root     (root)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (status.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (status.done) begin
            m_tdata_reg <= OUT_DATA_W'(root);
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/ikr_checker.sv -----
// Port-level checks for the k-th root block, bound to the top level.
module ikr_checker
    import ikr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // After an operand transfer the block is busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new operand taken while busy");

    // No result appears in the cycle right after an operand transfer
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too early");

endmodule

bind integer_kth_root_top ikr_checker u_ikr_checker (.*);
